/* hw/rtl/hopscotch_hash_table_engine_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the hopscotch hash table engine
// Shorthand for clocked, reset-qualified assertions.
// ----------------------------------------------------------------------------
`ifndef HOPSCOTCH_HASH_TABLE_ENGINE_TOP_ASSERT_SVH
`define HOPSCOTCH_HASH_TABLE_ENGINE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HHTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HHTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/hhte_pkg.sv */
// ----------------------------------------------------------------------------
// hhte_pkg
// Shared types, constants and helpers of the hopscotch hash table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hhte_pkg;

  localparam int KeyWords   = 8;
  localparam int KeyBits    = 64 * KeyWords;
  localparam int CountBits  = 11;
  localparam int HashBits   = 32;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdRemove = 2'd1;
  localparam logic [1:0] CmdLookup = 2'd2;
  localparam logic [1:0] CmdNone   = 2'd3;

  localparam logic [1:0] HashMix   = 2'd0;
  localparam logic [1:0] HashOaat  = 2'd1;
  localparam logic [1:0] HashConst = 2'd2;
  localparam logic [1:0] HashSpare = 2'd3;

  localparam logic [63:0] MixC0 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] MixC1 = 64'hC6BC279692B5CC83;
  localparam logic [63:0] MixC2 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixC3 = 64'hFF51AFD7ED558CCD;

  localparam int DefSlots        = 1024;
  localparam int DefNeighborhood = 32;
  localparam int DefWindowFactor = 2;
  localparam int DefValueBytes   = 8;

  typedef enum logic [1:0] {HS_IDLE, HS_MIX, HS_OAAT, HS_FIN} hash_state_t;
  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_HASH, ST_PROBE} eng_state_t;

  typedef struct packed {
    logic       go;
    logic [1:0] sel;
  } hash_req_t;

  typedef struct packed {
    logic                done;
    logic [HashBits-1:0] hash;
  } hash_rsp_t;

  // Multiplier constant of mixing step 1..8; step 8 is the finalizer.
  function automatic logic [63:0] mix_const(input logic [3:0] step);
    logic [63:0] c;
    unique case (step)
      4'd2, 4'd6: c = MixC2;
      4'd4:       c = MixC0;
      4'd8:       c = MixC3;
      default:    c = MixC1;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/hhte_hash.sv */
// ----------------------------------------------------------------------------
// hhte_hash
// Key hash unit: multiply-mix over a shared 32x32 multiplier, or a
// one-at-a-time hash one byte per cycle, or the constant one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hhte_hash (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hhte_pkg::hash_req_t           req,
  input  logic [hhte_pkg::KeyBits-1:0]  key,
  output hhte_pkg::hash_rsp_t           rsp
);

  hhte_pkg::hash_state_t state_r, state_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] ma_r, ma_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [5:0]  byte_r, byte_nxt;
  logic        done_r, done_nxt;
  logic [31:0] hash_r, hash_nxt;

  logic [63:0] c;
  logic [31:0] mx, my;
  logic [63:0] prod;
  logic [63:0] mres, fx;
  logic [31:0] t0, t1, t2, f0, f1, f2;
  logic [7:0]  bsel;

  assign c    = hhte_pkg::mix_const(step_r);
  assign prod = 64'(mx) * 64'(my);
  assign mres = acc_r + {prod[31:0], 32'd0};
  assign fx   = mres ^ (mres >> 33);
  assign bsel = key[{byte_r, 3'b000} +: 8];
  assign t0   = h_r[31:0] + {24'd0, bsel};
  assign t1   = t0 + (t0 << 10);
  assign t2   = t1 ^ (t1 >> 6);
  assign f0   = h_r[31:0] + (h_r[31:0] << 3);
  assign f1   = f0 ^ (f0 >> 11);
  assign f2   = f1 + (f1 << 15);

  always_comb begin
    unique case (ph_r)
      2'd1:    begin mx = ma_r[31:0];  my = c[31:0];  end
      2'd2:    begin mx = ma_r[31:0];  my = c[63:32]; end
      default: begin mx = ma_r[63:32]; my = c[31:0];  end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    ma_nxt    = ma_r;
    acc_nxt   = acc_r;
    step_nxt  = step_r;
    ph_nxt    = ph_r;
    byte_nxt  = byte_r;
    done_nxt  = 1'b0;
    hash_nxt  = hash_r;
    unique case (state_r)
      hhte_pkg::HS_IDLE: begin
        if (req.go) begin
          priority if (req.sel == hhte_pkg::HashMix) begin
            h_nxt     = key[63:0] ^ hhte_pkg::MixC0;
            step_nxt  = 4'd1;
            ph_nxt    = 2'd0;
            state_nxt = hhte_pkg::HS_MIX;
          end else if (req.sel == hhte_pkg::HashOaat) begin
            h_nxt     = 64'd0;
            byte_nxt  = 6'd0;
            state_nxt = hhte_pkg::HS_OAAT;
          end else begin
            hash_nxt = 32'd1;
            done_nxt = 1'b1;
          end
        end
      end
      hhte_pkg::HS_MIX: begin
        unique case (ph_r)
          2'd0: begin
            if (step_r[3]) ma_nxt = h_r ^ (h_r >> 33);
            else ma_nxt = h_r ^ key[{step_r[2:0], 6'd0} +: 64];
            ph_nxt = 2'd1;
          end
          2'd1: begin
            acc_nxt = prod;
            ph_nxt  = 2'd2;
          end
          2'd2: begin
            acc_nxt = mres;
            ph_nxt  = 2'd3;
          end
          default: begin
            h_nxt  = mres;
            ph_nxt = 2'd0;
            if (step_r[3]) begin
              hash_nxt  = fx[31:0] ^ fx[63:32];
              done_nxt  = 1'b1;
              state_nxt = hhte_pkg::HS_IDLE;
            end else begin
              step_nxt = step_r + 4'd1;
            end
          end
        endcase
      end
      hhte_pkg::HS_OAAT: begin
        h_nxt = {32'd0, t2};
        byte_nxt = byte_r + 6'd1;
        if (byte_r == 6'd63) state_nxt = hhte_pkg::HS_FIN;
      end
      default: begin
        hash_nxt  = f2;
        done_nxt  = 1'b1;
        state_nxt = hhte_pkg::HS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hhte_pkg::HS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    h_r    <= h_nxt;
    ma_r   <= ma_nxt;
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
    ph_r   <= ph_nxt;
    byte_r <= byte_nxt;
    hash_r <= hash_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.hash = hash_r;

endmodule

/* hw/rtl/hopscotch_hash_table_engine_top.sv */
// ----------------------------------------------------------------------------
// hopscotch_hash_table_engine_top
// Key-value table with 512-bit keys, hopscotch-style neighborhood probing.
// ----------------------------------------------------------------------------
// Usage: raise start with a command, a key and a value while busy is low; the
// item is taken at that edge and busy rises until the command is done. Each
// item gives exactly one result, shown for one cycle with out_valid high; the
// receiver cannot stall and must take it then. The hash select register is
// written through cfg_we/cfg_wdata; the user must write it only while the
// block is idle; the block itself does not enforce this. The go request to
// the hash unit is registered. Multiply-mix runs its mixing steps and a
// finalizing multiply through the one 32x32 multiplier, byte-at-a-time takes
// the key byte by byte and then finalizes, and the constant hash gives 1.
// The hash result is registered. The probe then reads one slot per cycle
// from the tag, key and value memories, at most WINDOW_FACTOR*NEIGHBORHOOD
// slots, and decides on each slot when its registered read data arrives.
// The result follows one cycle later, with busy already low, so the next
// item may be taken in that cycle. An unused command code returns its result
// the cycle after start. After reset the block clears all SLOTS rows of its
// memories, one row per cycle, holding busy high until the last is cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hopscotch_hash_table_engine_top #(
  parameter int SLOTS         = hhte_pkg::DefSlots,
  parameter int NEIGHBORHOOD  = hhte_pkg::DefNeighborhood,
  parameter int WINDOW_FACTOR = hhte_pkg::DefWindowFactor,
  parameter int VALUE_BYTES   = hhte_pkg::DefValueBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_key_word0,
  input  logic [63:0] in_key_word1,
  input  logic [63:0] in_key_word2,
  input  logic [63:0] in_key_word3,
  input  logic [63:0] in_key_word4,
  input  logic [63:0] in_key_word5,
  input  logic [63:0] in_key_word6,
  input  logic [63:0] in_key_word7,
  input  logic [63:0] in_value_in,
  output logic        out_valid,
  output logic        out_success,
  output logic [63:0] out_value_out,
  output logic [10:0] out_entries_used,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  localparam int SB = $clog2(SLOTS);
  localparam int W  = WINDOW_FACTOR * NEIGHBORHOOD;
  localparam int IW = $clog2(W + 1);
  localparam int SW = ((SB > IW) ? SB : IW) + 1;
  localparam int KB = hhte_pkg::KeyBits;
  localparam int CB = hhte_pkg::CountBits;
  localparam logic [63:0] ValMask = {64{1'b1}} >> (64 - 8 * VALUE_BYTES);
  localparam logic [CB-1:0] CountMax = {CB{1'b1}};

  // Table memories: one row per slot.
  logic [31:0]   tag_mem [SLOTS];
  logic [KB-1:0] key_mem [SLOTS];
  logic [63:0]   val_mem [SLOTS];
  logic [31:0]   tag_q;
  logic [KB-1:0] key_q;
  logic [63:0]   val_q;

  hhte_pkg::eng_state_t state_r, state_nxt;
  logic [1:0]    hsel_r;
  logic [1:0]    cmd_r;
  logic [KB-1:0] key_r;
  logic [63:0]   val_r;
  logic [31:0]   h_r;
  logic [SB-1:0] home_r;
  logic [SB-1:0] clr_r;
  logic [IW-1:0] i_r;
  logic          go_r;
  logic          ev_v_r;
  logic [IW-1:0] ev_i_r;
  logic [SB-1:0] ev_idx_r;
  logic          ev_over_r;
  logic          emp_v_r, emp_v_nxt;
  logic [SB-1:0] emp_idx_r, emp_idx_nxt;
  logic [CB-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic          out_success_r;
  logic [63:0]   out_value_r;
  logic [CB-1:0] out_count_r;

  hhte_pkg::hash_req_t hreq;
  hhte_pkg::hash_rsp_t hrsp;

  logic          accept;
  logic [SW-1:0] sum;
  logic [SB-1:0] rd_addr;
  logic          issue;
  logic          finish, fin_ok;
  logic [63:0]   fin_val;
  logic          we_tag, we_key, we_val;
  logic [SB-1:0] wa;
  logic [31:0]   wd_tag;
  logic [KB-1:0] wd_key;
  logic [63:0]   wd_val;
  logic          hit;

  assign accept  = start && !busy;
  assign busy    = (state_r != hhte_pkg::ST_IDLE);
  assign sum     = SW'(home_r) + SW'(i_r);
  assign rd_addr = sum[SB-1:0];
  assign issue   = (state_r == hhte_pkg::ST_PROBE) && (i_r < IW'(W)) && !finish;
  assign hit     = (tag_q == h_r) && (key_q == key_r);

  // The go request is registered, so the hash unit starts once the key
  // register holds the new key.
  assign hreq = {go_r, hsel_r};

  hhte_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .key   (key_r),
    .rsp   (hrsp)
  );

  // Sequencer and slot evaluation. A slot's read data arrives in the cycle
  // after its address was issued; the decision is taken on that data.
  always_comb begin
    state_nxt   = state_r;
    emp_v_nxt   = emp_v_r;
    emp_idx_nxt = emp_idx_r;
    count_nxt   = count_r;
    finish      = 1'b0;
    fin_ok      = 1'b0;
    fin_val     = 64'd0;
    we_tag      = 1'b0;
    we_key      = 1'b0;
    we_val      = 1'b0;
    wa          = ev_idx_r;
    wd_tag      = h_r;
    wd_key      = key_r;
    wd_val      = val_r & ValMask;
    unique case (state_r)
      hhte_pkg::ST_CLEAR: begin
        we_tag = 1'b1;
        we_key = 1'b1;
        we_val = 1'b1;
        wa     = clr_r;
        wd_tag = 32'd0;
        wd_key = '0;
        wd_val = 64'd0;
        if (clr_r == {SB{1'b1}}) state_nxt = hhte_pkg::ST_IDLE;
      end
      hhte_pkg::ST_IDLE: begin
        if (accept && in_command != hhte_pkg::CmdNone) state_nxt = hhte_pkg::ST_HASH;
      end
      hhte_pkg::ST_HASH: begin
        if (hrsp.done) begin
          state_nxt = hhte_pkg::ST_PROBE;
          emp_v_nxt = 1'b0;
        end
      end
      default: begin
        if (ev_v_r) begin
          if (cmd_r == hhte_pkg::CmdInsert) begin
            if (ev_i_r < IW'(NEIGHBORHOOD)) begin
              priority if (hit) begin
                // Key already present in the neighborhood: update its value.
                finish = 1'b1;
                fin_ok = 1'b1;
                we_val = 1'b1;
              end else if (ev_i_r == IW'(NEIGHBORHOOD - 1)) begin
                if (emp_v_r || tag_q == 32'd0) begin
                  finish = 1'b1;
                  fin_ok = 1'b1;
                  we_tag = 1'b1;
                  we_key = 1'b1;
                  we_val = 1'b1;
                  wa     = emp_v_r ? emp_idx_r : ev_idx_r;
                end else if (W == NEIGHBORHOOD) begin
                  finish = 1'b1;
                end
              end else if (tag_q == 32'd0 && !emp_v_r) begin
                emp_v_nxt   = 1'b1;
                emp_idx_nxt = ev_idx_r;
              end
            end else begin
              // Beyond the neighborhood the window does not wrap.
              priority if (ev_over_r) begin
                finish = 1'b1;
              end else if (tag_q == 32'd0) begin
                finish = 1'b1;
                fin_ok = 1'b1;
                we_tag = 1'b1;
                we_key = 1'b1;
                we_val = 1'b1;
              end else if (ev_i_r == IW'(W - 1)) begin
                finish = 1'b1;
              end
            end
            if (we_tag && count_r != CountMax) count_nxt = count_r + CB'(1);
          end else begin
            if (hit) begin
              finish = 1'b1;
              fin_ok = 1'b1;
              if (cmd_r == hhte_pkg::CmdRemove) begin
                we_tag = 1'b1;
                we_key = 1'b1;
                we_val = 1'b1;
                wd_tag = 32'd0;
                wd_key = '0;
                wd_val = 64'd0;
                if (count_r != '0) count_nxt = count_r - CB'(1);
              end else begin
                fin_val = val_q;
              end
            end else if (ev_i_r == IW'(W - 1)) begin
              finish = 1'b1;
            end
          end
        end
        if (finish) state_nxt = hhte_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_tag) tag_mem[wa] <= wd_tag;
    if (we_key) key_mem[wa] <= wd_key;
    if (we_val) val_mem[wa] <= wd_val;
    tag_q <= tag_mem[rd_addr];
    key_q <= key_mem[rd_addr];
    val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hhte_pkg::ST_CLEAR;
      clr_r       <= '0;
      hsel_r      <= 2'd0;
      count_r     <= '0;
      go_r        <= 1'b0;
      ev_v_r      <= 1'b0;
      emp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      go_r        <= accept && (in_command != hhte_pkg::CmdNone);
      emp_v_r     <= emp_v_nxt;
      ev_v_r      <= issue;
      out_valid_r <= finish || (accept && in_command == hhte_pkg::CmdNone);
      if (state_r == hhte_pkg::ST_CLEAR) clr_r <= clr_r + SB'(1);
      if (cfg_we) hsel_r <= cfg_wdata;
    end
    emp_idx_r <= emp_idx_nxt;
    ev_i_r    <= i_r;
    ev_idx_r  <= rd_addr;
    ev_over_r <= (i_r >= IW'(NEIGHBORHOOD)) && (sum >= SW'(SLOTS));
    if (accept) begin
      cmd_r <= in_command;
      key_r <= {in_key_word7, in_key_word6, in_key_word5, in_key_word4,
                in_key_word3, in_key_word2, in_key_word1, in_key_word0};
      val_r <= in_value_in;
    end
    if (state_r == hhte_pkg::ST_HASH) begin
      h_r    <= hrsp.hash;
      home_r <= hrsp.hash[SB-1:0];
      i_r    <= '0;
    end else if (issue) begin
      i_r <= i_r + IW'(1);
    end
    out_success_r <= fin_ok;
    out_value_r   <= fin_val;
    out_count_r   <= count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_success      = out_success_r;
  assign out_value_out    = out_value_r;
  assign out_entries_used = out_count_r;

`include "hopscotch_hash_table_engine_top_assert.svh"

  `HHTE_ASSERT_NOW(a_no_out_clear, state_r == hhte_pkg::ST_CLEAR, !out_valid_r, "result in clear")
  `HHTE_ASSERT_NOW(a_fail_zero, out_valid_r && !out_success_r, out_value_r == '0, "failed value")
  `HHTE_ASSERT_NEXT(a_busy_start, accept && in_command != hhte_pkg::CmdNone, busy, "no busy")
  `HHTE_ASSERT_NEXT(a_cnt_idle, state_r == hhte_pkg::ST_IDLE, count_r == $past(count_r), "count")

endmodule
